[design/vta_pkg.sv]
// Shared widths, character codes and the result-run type for the VT52 to
// ANSI translator. No dependencies; every other design file imports this.

package vta_pkg;

	// channel and run geometry
	localparam int BYTE_W  = 8;
	localparam int SEQ_MAX = 10;
	localparam int CNT_W   = 4;
	localparam int ROW_W   = 9;

	// configuration port
	localparam int ADDR_W = 1;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] CFG_VBELL_ADDR = 1'b0;

	// control characters
	localparam logic [BYTE_W-1:0] A_SOH = 8'h01;
	localparam logic [BYTE_W-1:0] A_STX = 8'h02;
	localparam logic [BYTE_W-1:0] A_ETX = 8'h03;
	localparam logic [BYTE_W-1:0] A_ENQ = 8'h05;
	localparam logic [BYTE_W-1:0] A_BEL = 8'h07;
	localparam logic [BYTE_W-1:0] A_FF  = 8'h0C;
	localparam logic [BYTE_W-1:0] A_DC2 = 8'h12;
	localparam logic [BYTE_W-1:0] A_DC3 = 8'h13;
	localparam logic [BYTE_W-1:0] A_CAN = 8'h18;
	localparam logic [BYTE_W-1:0] A_SUB = 8'h1A;
	localparam logic [BYTE_W-1:0] A_ESC = 8'h1B;
	localparam logic [BYTE_W-1:0] A_RS  = 8'h1E;
	localparam logic [BYTE_W-1:0] A_DEL = 8'h7F;

	// printable characters used by the decoder
	localparam logic [BYTE_W-1:0] A_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] A_STAR  = 8'h2A;
	localparam logic [BYTE_W-1:0] A_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] A_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] A_SEVEN = 8'h37;
	localparam logic [BYTE_W-1:0] A_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] A_EQ    = 8'h3D;
	localparam logic [BYTE_W-1:0] A_B     = 8'h42;
	localparam logic [BYTE_W-1:0] A_C     = 8'h43;
	localparam logic [BYTE_W-1:0] A_D     = 8'h44;
	localparam logic [BYTE_W-1:0] A_E     = 8'h45;
	localparam logic [BYTE_W-1:0] A_H     = 8'h48;
	localparam logic [BYTE_W-1:0] A_L     = 8'h4C;
	localparam logic [BYTE_W-1:0] A_R     = 8'h52;
	localparam logic [BYTE_W-1:0] A_Y     = 8'h59;
	localparam logic [BYTE_W-1:0] A_LBRK  = 8'h5B;

	// cursor operand bias: byte - 0x20 + 1, modulo 2^ROW_W
	localparam logic [ROW_W-1:0] ROW_BIAS = 9'h1E1;

	// one run of result bytes; b[0] leaves first
	typedef struct packed {
		logic [SEQ_MAX-1:0][BYTE_W-1:0] b;
		logic [CNT_W-1:0]               len;
	} seq_t;

endpackage

[design/vta_in_if.sv]
// Input byte channel of the VT52 to ANSI translator: valid/ready plus in_byte.
// Depends on vta_pkg.

interface vta_in_if import vta_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

[design/vta_out_if.sv]
// Output byte channel of the VT52 to ANSI translator: valid/ready plus
// out_byte and out_last. Depends on vta_pkg.

interface vta_out_if import vta_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[design/vt52_to_ansi_translator_unit.sv]
// VT52/ADM3A to ANSI translator, top level.
// Depends on vta_pkg, vta_in_if and vta_out_if.
//
// Each guest byte is decoded in the cycle it is accepted and its whole ANSI
// run (zero to ten bytes) is loaded into a ten-byte output shift register,
// which then drains one byte per cycle while the host accepts, out_last
// marking the final byte of the run. A new guest byte is taken in the same
// cycle the last byte of the previous run is taken, and not before; bytes
// that produce nothing sustain one byte per cycle, as does single-byte
// pass-through while the host takes every byte. The drain of the output
// shift register paces longer runs. Register 0 (byte address 0, bit 0)
// enables the visual bell; write it only while the block is idle.

module vt52_to_ansi_translator_unit import vta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	vta_in_if.sink            guest,
	vta_out_if.source         host,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ESC,
		ST_ROW,
		ST_COL,
		ST_ATTR_ON,
		ST_ATTR_OFF,
		ST_SKIP4,
		ST_SKIP3,
		ST_SKIP2,
		ST_SKIP1
	} state_t;

	typedef struct packed {
		logic [2:0][BYTE_W-1:0] ch;
		logic [1:0]             len;
	} dec_t;

	state_t                         st_q, st_d;
	logic [ROW_W-1:0]               row_q, row_d;
	logic [CNT_W-1:0]               cnt_q;
	logic [SEQ_MAX-1:0][BYTE_W-1:0] buf_q;
	logic                           vbell_q;
	seq_t                           seq_d;
	logic                           in_fire, out_fire;
	logic [BYTE_W-1:0]              c;

	// left-justify a string literal of n characters into a run
	function automatic seq_t mk_seq(input logic [SEQ_MAX*BYTE_W-1:0] s,
			input logic [CNT_W-1:0] n);
		seq_t                        r;
		logic [SEQ_MAX*BYTE_W-1:0] sl;
		sl = s << (BYTE_W * (SEQ_MAX - int'(n)));
		for (int i = 0; i < SEQ_MAX; i++) begin
			r.b[i] = sl[SEQ_MAX*BYTE_W-1-BYTE_W*i -: BYTE_W];
		end
		r.len = n;
		return r;
	endfunction

	// run of up to three literal bytes
	function automatic seq_t mk_bytes(input logic [BYTE_W-1:0] b0,
			input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
			input logic [CNT_W-1:0] n);
		seq_t r;
		r      = '0;
		r.b[0] = b0;
		r.b[1] = b1;
		r.b[2] = b2;
		r.len  = n;
		return r;
	endfunction

	// signed decimal of a value in -31..224
	function automatic dec_t dec_str(input logic [ROW_W-1:0] v);
		dec_t        r;
		logic        neg;
		logic [7:0]  m;
		logic [1:0]  h;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [3:0]  t, o;
		neg = v[ROW_W-1];
		m   = neg ? 8'(~v + 9'd1) : v[7:0];
		if (m >= 8'd200) begin
			h   = 2'd2;
			rem = 7'(m - 8'd200);
		end else if (m >= 8'd100) begin
			h   = 2'd1;
			rem = 7'(m - 8'd100);
		end else begin
			h   = 2'd0;
			rem = m[6:0];
		end
		// tens by reciprocal: x * 205 >> 11 is exact below 100
		prod = 15'(rem) * 15'd205;
		t    = prod[14:11];
		o    = 4'(rem - 7'(t) * 7'd10);
		r    = '0;
		if (neg) begin
			r.ch[0] = A_MINUS;
			if (m >= 8'd10) begin
				r.ch[1] = 8'(A_ZERO + t);
				r.ch[2] = 8'(A_ZERO + o);
				r.len   = 2'd3;
			end else begin
				r.ch[1] = 8'(A_ZERO + o);
				r.len   = 2'd2;
			end
		end else if (h != 2'd0) begin
			r.ch[0] = 8'(A_ZERO + h);
			r.ch[1] = 8'(A_ZERO + t);
			r.ch[2] = 8'(A_ZERO + o);
			r.len   = 2'd3;
		end else if (m >= 8'd10) begin
			r.ch[0] = 8'(A_ZERO + t);
			r.ch[1] = 8'(A_ZERO + o);
			r.len   = 2'd2;
		end else begin
			r.ch[0] = 8'(A_ZERO + o);
			r.len   = 2'd1;
		end
		return r;
	endfunction

	// ESC [ row ; col H
	function automatic seq_t cursor_seq(input logic [ROW_W-1:0] row,
			input logic [ROW_W-1:0] col);
		seq_t r;
		dec_t rd, cd;
		int   lr, lc;
		rd = dec_str(row);
		cd = dec_str(col);
		lr = int'(rd.len);
		lc = int'(cd.len);
		for (int p = 0; p < SEQ_MAX; p++) begin
			if (p == 0) begin
				r.b[p] = A_ESC;
			end else if (p == 1) begin
				r.b[p] = A_LBRK;
			end else if (p < 2 + lr) begin
				r.b[p] = rd.ch[2'(p - 2)];
			end else if (p == 2 + lr) begin
				r.b[p] = A_SEMI;
			end else if (p < 3 + lr + lc) begin
				r.b[p] = cd.ch[2'(p - 3 - lr)];
			end else if (p == 3 + lr + lc) begin
				r.b[p] = A_H;
			end else begin
				r.b[p] = '0;
			end
		end
		r.len = CNT_W'(4 + lr + lc);
		return r;
	endfunction

	// attribute selector table, on and off forms
	function automatic seq_t attr_seq(input logic [2:0] sel, input logic on);
		seq_t r;
		case (sel)
			3'd0: r = on ? mk_seq("\033[7m", 4'd4) : mk_seq("\033[27m", 4'd5);
			3'd1: r = on ? mk_seq("\033[1m", 4'd4) : mk_seq("\033[m", 4'd3);
			3'd2: r = on ? mk_seq("\033[5m", 4'd4) : mk_seq("\033[25m", 4'd5);
			3'd3: r = on ? mk_seq("\033[4m", 4'd4) : mk_seq("\033[24m", 4'd5);
			3'd4: r = on ? mk_seq("\033[?25h", 4'd6) : mk_seq("\033[?25l", 4'd6);
			3'd6: r = on ? mk_seq("\033[s", 4'd3) : mk_seq("\033[u", 4'd3);
			default: r = '0;
		endcase
		return r;
	endfunction

	// handshakes
	assign c          = guest.in_byte;
	assign guest.ready = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && host.ready);
	assign in_fire    = guest.valid && guest.ready;
	assign out_fire   = host.valid && host.ready;
	assign host.valid    = (cnt_q != '0);
	assign host.out_byte = buf_q[0];
	assign host.out_last = (cnt_q == CNT_W'(1));

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == CFG_VBELL_ADDR) ? DATA_W'(vbell_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbell_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == CFG_VBELL_ADDR)) begin
			vbell_q <= pwdata[0];
		end
	end

	// byte decoder: next state and the whole result run
	always_comb begin
		st_d  = st_q;
		row_d = row_q;
		seq_d = '0;
		unique case (st_q)
			ST_IDLE: begin
				unique case (c) inside
					A_BEL: begin
						if (vbell_q) seq_d = mk_seq("\033[?5h\033[?5l", 4'd10);
						else seq_d = mk_bytes(c, '0, '0, 4'd1);
					end
					A_DEL: seq_d = mk_seq("\010 \010", 4'd3);
					A_SUB, A_FF: seq_d = mk_seq("\033[H\033[2J", 4'd7);
					A_RS: seq_d = mk_seq("\033[H", 4'd3);
					A_ESC: st_d = ST_ESC;
					A_SOH: st_d = ST_ROW;
					A_STX: seq_d = mk_seq("\033[L", 4'd3);
					A_ETX: seq_d = mk_seq("\033[M", 4'd3);
					A_CAN, A_ENQ: seq_d = mk_seq("\033[K", 4'd3);
					A_DC2, A_DC3: seq_d = '0;
					default: seq_d = mk_bytes(c, '0, '0, 4'd1);
				endcase
			end
			ST_ESC: begin
				unique case (c) inside
					A_ESC: seq_d = mk_bytes(A_ESC, '0, '0, 4'd1);
					A_EQ, A_Y: st_d = ST_ROW;
					A_E: begin
						seq_d = mk_seq("\033[L", 4'd3);
						st_d  = ST_IDLE;
					end
					A_R: begin
						seq_d = mk_seq("\033[M", 4'd3);
						st_d  = ST_IDLE;
					end
					A_B: st_d = ST_ATTR_ON;
					A_C: st_d = ST_ATTR_OFF;
					A_L, A_D: st_d = ST_SKIP4;
					A_STAR, A_SPACE: st_d = ST_SKIP2;
					default: begin
						seq_d = mk_bytes(A_ESC, c, '0, 4'd2);
						st_d  = ST_IDLE;
					end
				endcase
			end
			ST_ROW: begin
				row_d = ROW_W'({1'b0, c} + ROW_BIAS);
				st_d  = ST_COL;
			end
			ST_COL: begin
				seq_d = cursor_seq(row_q, ROW_W'({1'b0, c} + ROW_BIAS));
				st_d  = ST_IDLE;
			end
			ST_ATTR_ON, ST_ATTR_OFF: begin
				st_d = ST_IDLE;
				if (c >= A_ZERO && c <= A_SEVEN) begin
					seq_d = attr_seq(c[2:0], st_q == ST_ATTR_ON);
				end else begin
					seq_d = mk_bytes(A_ESC, (st_q == ST_ATTR_ON) ? A_B : A_C, c, 4'd3);
				end
			end
			ST_SKIP4: st_d = ST_SKIP3;
			ST_SKIP3: st_d = ST_SKIP2;
			ST_SKIP2: st_d = ST_SKIP1;
			ST_SKIP1: st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// parse state, row and run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			row_q <= '0;
			cnt_q <= '0;
		end else if (in_fire) begin
			st_q  <= st_d;
			row_q <= row_d;
			cnt_q <= seq_d.len;
		end else if (out_fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// output shift register: load a run, shift one byte per transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			buf_q <= seq_d.b;
		end else if (out_fire) begin
			buf_q <= {BYTE_W'(0), buf_q[SEQ_MAX-1:1]};
		end
	end

endmodule

[design/vta_checker.sv]
// Port-level checks for the VT52 to ANSI translator, with the bind that
// attaches them to the top level. Depends on vta_pkg.

module vta_checker import vta_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              guest_ready,
	input logic              host_valid,
	input logic              host_ready,
	input logic              host_last,
	input logic [BYTE_W-1:0] out_byte
);

	// a stalled result transaction holds its payload
	a_host_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(host_valid && !host_ready) |=>
			(host_valid && $stable(out_byte) && $stable(host_last)))
		else $error("host transaction dropped or changed while stalled");

	// nothing pending on the host side: the guest side must be open
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!host_valid |-> guest_ready)
		else $error("guest stalled with no result pending");

	// mid-run: no new guest byte may be taken
	a_midrun_block: assert property (@(posedge clk) disable iff (!arst_n)
		(host_valid && !host_last) |-> !guest_ready)
		else $error("guest byte taken in the middle of a run");

	// final byte stalled: the guest side waits
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(host_valid && host_last && !host_ready) |-> !guest_ready)
		else $error("guest byte taken while final result byte stalled");

endmodule

bind vt52_to_ansi_translator_unit vta_checker u_vta_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.guest_ready (guest.ready),
	.host_valid  (host.valid),
	.host_ready  (host.ready),
	.host_last   (host.out_last),
	.out_byte    (host.out_byte)
);

[tb/vt52_to_ansi_translator_unit_tb.sv]
// Self-checking testbench for vt52_to_ansi_translator_unit: drives guest bytes,
// predicts the ANSI output runs and checks every host transaction in order.
// Depends on vta_pkg, vta_in_if, vta_out_if and the translator RTL.

module vt52_to_ansi_translator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vta_pkg::*;

	localparam logic [BYTE_W-1:0] A_BS = 8'h08;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_ITEMS = 150;

	// parse states of the translator
	typedef enum logic [3:0] {
		P_IDLE, P_ESC, P_ROW, P_COL, P_ATTR_ON, P_ATTR_OFF,
		P_SKIP_1, P_SKIP_2, P_SKIP_3, P_SKIP_4
	} parse_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} host_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic              psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	vta_in_if  guest_ch ();
	vta_out_if host_ch ();

	vt52_to_ansi_translator_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.guest   (guest_ch),
		.host    (host_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// predictor state and traffic stores
	parse_phase_t      parse_st = P_IDLE;
	logic [ROW_W-1:0]  row_reg  = '0;
	logic              bell_on  = 1'b0;
	logic [BYTE_W-1:0] ansi_run[$];
	host_beat_t        ansi_due[$];
	logic [BYTE_W-1:0] guest_pending[$];
	logic [BYTE_W-1:0] ctl_codes[$];

	int tx_idle_pct, rx_idle_pct;
	int rx_hold_left = 0;
	int quiet_cycles = 0;
	int errs = 0, bytes_in = 0, beats_checked = 0, cfg_writes = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch: %s got 0x%02h want 0x%02h", $time, what, got, want);
		errs++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			ansi_run.push_back(s[i]);
	endtask

	task automatic push_csi(input string tail);
		ansi_run.push_back(A_ESC);
		ansi_run.push_back(A_LBRK);
		push_text(tail);
	endtask

	function automatic string attr_tail(input logic on, input logic [2:0] sel);
		case (sel)
			3'd0: return on ? "7m" : "27m";
			3'd1: return on ? "1m" : "m";
			3'd2: return on ? "5m" : "25m";
			3'd3: return on ? "4m" : "24m";
			3'd4: return on ? "?25h" : "?25l";
			3'd6: return on ? "s" : "u";
			default: return "";
		endcase
	endfunction

	// works out the ANSI run for one accepted guest byte and queues it
	task automatic translate_guest_byte(input logic [BYTE_W-1:0] c);
		int    row, col;
		logic  attr_on;
		string tail;
		ansi_run.delete();
		case (parse_st)
			P_IDLE: begin
				case (c)
					A_BEL: begin
						if (bell_on) begin
							push_csi("?5h");
							push_csi("?5l");
						end else begin
							ansi_run.push_back(c);
						end
					end
					A_DEL: begin
						ansi_run.push_back(A_BS);
						ansi_run.push_back(A_SPACE);
						ansi_run.push_back(A_BS);
					end
					A_SUB, A_FF: begin
						push_csi("H");
						push_csi("2J");
					end
					A_RS:         push_csi("H");
					A_ESC:        parse_st = P_ESC;
					A_SOH:        parse_st = P_ROW;
					A_STX:        push_csi("L");
					A_ETX:        push_csi("M");
					A_CAN, A_ENQ: push_csi("K");
					A_DC2, A_DC3: ;
					default:      ansi_run.push_back(c);
				endcase
			end
			P_ESC: begin
				case (c)
					A_ESC:        ansi_run.push_back(A_ESC);
					A_EQ, A_Y:    parse_st = P_ROW;
					A_E: begin
						push_csi("L");
						parse_st = P_IDLE;
					end
					A_R: begin
						push_csi("M");
						parse_st = P_IDLE;
					end
					A_B:          parse_st = P_ATTR_ON;
					A_C:          parse_st = P_ATTR_OFF;
					A_L, A_D:     parse_st = P_SKIP_1;
					A_STAR, A_SPACE: parse_st = P_SKIP_3;
					default: begin
						parse_st = P_IDLE;
						ansi_run.push_back(A_ESC);
						ansi_run.push_back(c);
					end
				endcase
			end
			P_ROW: begin
				row_reg  = ROW_W'(c) - ROW_W'(A_SPACE) + ROW_W'(1);
				parse_st = P_COL;
			end
			P_COL: begin
				row = $signed(row_reg);
				col = int'(c) - int'(A_SPACE) + 1;
				parse_st = P_IDLE;
				ansi_run.push_back(A_ESC);
				ansi_run.push_back(A_LBRK);
				push_text($sformatf("%0d", row));
				ansi_run.push_back(A_SEMI);
				push_text($sformatf("%0d", col));
				ansi_run.push_back(A_H);
			end
			P_ATTR_ON, P_ATTR_OFF: begin
				attr_on  = (parse_st == P_ATTR_ON);
				parse_st = P_IDLE;
				if (c >= A_ZERO && c <= A_SEVEN) begin
					tail = attr_tail(attr_on, c[2:0]);
					if (tail.len() != 0)
						push_csi(tail);
				end else begin
					ansi_run.push_back(A_ESC);
					ansi_run.push_back(attr_on ? A_B : A_C);
					ansi_run.push_back(c);
				end
			end
			P_SKIP_1: parse_st = P_SKIP_2;
			P_SKIP_2: parse_st = P_SKIP_3;
			P_SKIP_3: parse_st = P_SKIP_4;
			default:  parse_st = P_IDLE;
		endcase
		while (ansi_run.size() > SEQ_MAX)
			void'(ansi_run.pop_back());
		for (int i = 0; i < ansi_run.size(); i++)
			ansi_due.push_back('{data: ansi_run[i], last: (i == ansi_run.size() - 1)});
	endtask

	// guest side: offer pending bytes, predict on each accepted transaction
	always @(posedge clk) begin : guest_driver
		logic              offer;
		logic [BYTE_W-1:0] next_byte;
		if (!arst_n) begin
			guest_ch.valid <= 1'b0;
		end else begin
			offer     = guest_ch.valid;
			next_byte = guest_ch.in_byte;
			if (guest_ch.valid && guest_ch.ready) begin
				translate_guest_byte(guest_ch.in_byte);
				bytes_in++;
				offer = 1'b0;
			end
			if (!offer && guest_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_byte = guest_pending.pop_front();
				offer     = 1'b1;
			end
			guest_ch.valid   <= offer;
			guest_ch.in_byte <= next_byte;
		end
	end

	// host side: check each transaction against the oldest expected byte
	always @(posedge clk) begin : host_monitor
		host_beat_t want;
		if (!arst_n) begin
			host_ch.ready <= 1'b0;
		end else begin
			if (host_ch.valid && host_ch.ready) begin
				beats_checked++;
				if (ansi_due.size() == 0) begin
					report_mismatch("unexpected out_byte", host_ch.out_byte, 0);
				end else begin
					want = ansi_due.pop_front();
					if (host_ch.out_byte !== want.data)
						report_mismatch("out_byte", host_ch.out_byte, want.data);
					if (host_ch.out_last !== want.last)
						report_mismatch("out_last", host_ch.out_last, want.last);
				end
			end
			host_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// long host stall, counted down here once started
	always @(posedge clk)
		if (rx_hold_left != 0)
			rx_hold_left <= rx_hold_left - 1;

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if (!arst_n || (guest_ch.valid && guest_ch.ready) ||
				(host_ch.valid && host_ch.ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("vt52_to_ansi_translator_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_visual_bell(input logic v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_VBELL_ADDR;
		pwdata  <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		bell_on = v;
		cfg_writes++;
	endtask

	task automatic wait_host_drained();
		do
			@(negedge clk);
		while (guest_pending.size() != 0 || guest_ch.valid || ansi_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_guest_byte(input logic [BYTE_W-1:0] b);
		guest_pending.push_back(b);
	endtask

	// screen coordinates mostly, occasionally any byte
	function automatic logic [BYTE_W-1:0] coord_byte();
		if ($urandom_range(99) < 80)
			return BYTE_W'($urandom_range(8'h6F, 8'h20));
		return BYTE_W'($urandom_range(255));
	endfunction

	// one random sequence; every queued byte is counted
	task automatic queue_random_sequence(inout int counted);
		int kind;
		int pick;
		kind = $urandom_range(99);
		pick = $urandom_range(3);
		if (kind < 20) begin
			queue_guest_byte(BYTE_W'($urandom_range(255)));
			counted += 1;
		end else if (kind < 35) begin
			queue_guest_byte(ctl_codes[$urandom_range(ctl_codes.size() - 1)]);
			counted += 1;
		end else if (kind < 55) begin
			// cursor motion by any of its three prefixes
			if (pick == 0) begin
				queue_guest_byte(A_SOH);
				counted += 1;
			end else begin
				queue_guest_byte(A_ESC);
				queue_guest_byte(pick == 1 ? A_EQ : A_Y);
				counted += 2;
			end
			queue_guest_byte(coord_byte());
			queue_guest_byte(coord_byte());
			counted += 2;
		end else if (kind < 70) begin
			// attribute on/off with a selector
			queue_guest_byte(A_ESC);
			queue_guest_byte(pick[0] ? A_B : A_C);
			if ($urandom_range(99) < 85)
				queue_guest_byte(A_ZERO + BYTE_W'($urandom_range(7)));
			else
				queue_guest_byte(BYTE_W'($urandom_range(255)));
			counted += 3;
		end else if (kind < 85) begin
			// plain escape commands, doubled ESC and unknown codes
			queue_guest_byte(A_ESC);
			case (pick)
				0: queue_guest_byte(A_E);
				1: queue_guest_byte(A_R);
				2: begin
					queue_guest_byte(A_ESC);
					queue_guest_byte(A_E);
					counted += 1;
				end
				default: queue_guest_byte(BYTE_W'($urandom_range(255)));
			endcase
			counted += 2;
		end else if (kind < 95) begin
			// operand skips: four bytes after L/D, two after * or space
			queue_guest_byte(A_ESC);
			case (pick)
				0: queue_guest_byte(A_L);
				1: queue_guest_byte(A_D);
				2: queue_guest_byte(A_STAR);
				default: queue_guest_byte(A_SPACE);
			endcase
			counted += 2;
			repeat (pick < 2 ? 4 : 2)
				queue_guest_byte(BYTE_W'($urandom_range(255)));
			counted += (pick < 2) ? 4 : 2;
		end else begin
			// truncated prefix, the next sequence lands in the wrong state
			queue_guest_byte(pick[0] ? A_ESC : A_SOH);
			counted += 1;
		end
	endtask

	initial begin : stimulus
		int counted;
		guest_ch.valid   = 1'b0;
		guest_ch.in_byte = '0;
		host_ch.ready    = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;
		ctl_codes = '{A_BEL, A_DEL, A_SUB, A_FF, A_RS, A_STX, A_ETX,
			A_CAN, A_ENQ, A_DC2, A_DC3, A_ESC, A_SOH};
		tx_idle_pct = 37;
		rx_idle_pct = 47;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		write_visual_bell(1'b0);
		// directed: bell passes through, erase, doubled ESC then insert line
		queue_guest_byte(A_BEL);
		queue_guest_byte(A_DEL);
		queue_guest_byte(A_ESC);
		queue_guest_byte(A_ESC);
		queue_guest_byte(A_E);
		// most negative cursor address (longest run), then the largest
		queue_guest_byte(A_ESC);
		queue_guest_byte(A_Y);
		queue_guest_byte(8'h00);
		queue_guest_byte(8'h00);
		queue_guest_byte(A_SOH);
		queue_guest_byte(8'hFF);
		queue_guest_byte(8'hFF);
		// silent selectors, then an unknown selector
		queue_guest_byte(A_ESC);
		queue_guest_byte(A_B);
		queue_guest_byte(A_ZERO + 8'd5);
		queue_guest_byte(A_ESC);
		queue_guest_byte(A_C);
		queue_guest_byte(A_SEVEN);
		queue_guest_byte(A_ESC);
		queue_guest_byte(A_B);
		queue_guest_byte(8'h78);
		// unknown escape, then ESC L swallowing four ESC bytes
		queue_guest_byte(A_ESC);
		queue_guest_byte(8'h71);
		queue_guest_byte(A_ESC);
		queue_guest_byte(A_L);
		repeat (4) queue_guest_byte(A_ESC);
		wait_host_drained();

		// random, sender 37% and receiver 47% idle, visual bell on
		write_visual_bell(1'b1);
		queue_guest_byte(A_BEL);
		counted = 0;
		while (counted < PHASE_ITEMS)
			queue_random_sequence(counted);
		wait_host_drained();

		// random, idle rates swapped, visual bell off
		tx_idle_pct = 47;
		rx_idle_pct = 37;
		write_visual_bell(1'b0);
		counted = 0;
		while (counted < PHASE_ITEMS)
			queue_random_sequence(counted);
		wait_host_drained();

		// random at full rate, with one long host stall while bytes keep coming
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_visual_bell(1'b1);
		counted = 0;
		while (counted < PHASE_ITEMS)
			queue_random_sequence(counted);
		@(posedge clk);
		rx_hold_left <= LONG_HOLD;
		wait_host_drained();
		repeat (12) @(posedge clk);

		$display("covered: %0d guest bytes, %0d ANSI bytes checked, %0d bell register writes",
			bytes_in, beats_checked, cfg_writes);
		$display("covered: three idle mixes plus a %0d-cycle host stall", LONG_HOLD);
		if (errs == 0)
			$display("vt52_to_ansi_translator_unit regression: pass");
		else
			$display("vt52_to_ansi_translator_unit regression: fail");
		$finish;
	end

endmodule

[filelist.f]
design/vta_pkg.sv
design/vta_in_if.sv
design/vta_out_if.sv
design/vt52_to_ansi_translator_unit.sv
design/vta_checker.sv
tb/vt52_to_ansi_translator_unit_tb.sv
